// ===== design/assert_macros.svh =====
// assertion macros shared by the integer-to-words rtl
// expects clk and rst_n (active low) in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define NTEW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never hold outside reset
`define NTEW_NEVER(lbl, cond, msg) \
    `NTEW_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/ntew_pkg.sv =====
// shared types and constants for the integer-to-words block
// no dependencies
package ntew_pkg;

    localparam int VALUE_W    = 31;
    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CONV_STEPS = BIN_W / 2;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);
    localparam int NUM_GROUPS = 4;
    localparam int GROUP_POS  = 5;
    localparam int POS_N      = 1 + NUM_GROUPS * GROUP_POS;

    typedef logic [4:0]       code_t;
    typedef logic [3:0]       digit_t;
    typedef logic [BCD_W-1:0] bcd_t;

    localparam code_t CODE_ZERO     = 5'd0;
    localparam code_t CODE_TEN      = 5'd10;
    localparam code_t CODE_TWENTY   = 5'd20;
    localparam code_t CODE_HUNDRED  = 5'd28;
    localparam code_t CODE_THOUSAND = 5'd29;
    localparam code_t CODE_MILLION  = 5'd30;
    localparam code_t CODE_BILLION  = 5'd31;

    // front to queue transaction
    typedef struct packed {
        logic push;
        bcd_t bcd;
    } ntew_push_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic not_empty;
        bcd_t bcd;
    } ntew_head_t;

    // one double-dabble step: correct digits then shift one binary bit in
    function automatic bcd_t dd_step(input bcd_t bcd, input logic bin_bit);
        bcd_t adj;
        adj = bcd;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (adj[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

endpackage

// ===== design/number_to_english_word_tokens.sv =====
// top level of the integer-to-english word token block
// depends on ntew_pkg, ntew_front, ntew_queue, ntew_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------
//   input    | start, busy          | value[30:0]
//   result   | word_valid (strobe)  | word_code[4:0], last_word
//
// the front end converts a value by double dabble, two bits at a time, and hands
// the digits to the queue, waiting while it is full; a new value can be taken as the
// handoff happens. the back end emits one token per cycle, 1 to 16 per value.
// rst_n is asynchronous and clears all control state; the queue starts empty.
// busy is high while the front end converts or while it holds digits for a full
// queue. results are strobed for one cycle and cannot be stalled.
module number_to_english_word_tokens
    import ntew_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    output logic               word_valid,
    output logic [4:0]         word_code,
    output logic               last_word
);

    ntew_push_t push;
    ntew_head_t head;
    logic       q_full;
    logic       pop;

    // value intake and binary to decimal conversion
    ntew_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .q_full (q_full),
        .push   (push)
    );

    // decouples conversion from token emission
    ntew_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    // token sequencing
    ntew_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .word_valid (word_valid),
        .word_code  (word_code),
        .last_word  (last_word)
    );

endmodule

// ===== design/ntew_front.sv =====
// front end: accepts a value and converts it to decimal digits, two bits a cycle
// depends on ntew_pkg and assert_macros.svh
`include "assert_macros.svh"

module ntew_front
    import ntew_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    input  logic               q_full,
    output ntew_push_t         push
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    bcd_t                    bcd_reg, bcd_next;
    logic                    accept;
    logic                    do_push;

    // handshake
    assign do_push = (state_reg == F_PUSH) && !q_full;
    assign busy    = !((state_reg == F_IDLE) || do_push);
    assign accept  = start && !busy;

    assign push.push = do_push;
    assign push.bcd  = bcd_reg;

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        case (state_reg)
            F_IDLE, F_PUSH:
            begin
                if (do_push) begin
                    state_next = F_IDLE;
                end
                if (accept) begin
                    state_next = F_CONV;
                    cnt_next   = '0;
                    bin_next   = {{(BIN_W-VALUE_W){1'b0}}, value};
                    bcd_next   = '0;
                end
            end
            F_CONV:
            begin
                bcd_next = dd_step(dd_step(bcd_reg, bin_reg[BIN_W-1]), bin_reg[BIN_W-2]);
                bin_next = {bin_reg[BIN_W-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(CONV_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    `NTEW_ASSERT(a_front_busy_after_accept, accept |=> busy, "front not busy after accept")

endmodule

// ===== design/ntew_queue.sv =====
// short digit queue between front and back end
// depends on ntew_pkg and assert_macros.svh
`include "assert_macros.svh"

module ntew_queue
    import ntew_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ntew_push_t push,
    output logic       full,
    input  logic       pop,
    output ntew_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full           = (cnt_reg == CNT_W'(DEPTH));
    assign head.not_empty = (cnt_reg != '0);
    assign head.bcd       = mem_reg[rd_ptr_reg];
    assign do_push        = push.push && !full;
    assign do_pop         = pop && head.not_empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.bcd;
        end
    end

    `NTEW_NEVER(a_queue_overflow, push.push && full, "push into full queue")
    `NTEW_ASSERT(a_queue_count, cnt_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== design/ntew_back.sv =====
// back end: walks the decimal groups and emits one word token per cycle
// depends on ntew_pkg and assert_macros.svh
`include "assert_macros.svh"

module ntew_back
    import ntew_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ntew_head_t head,
    output logic       pop,
    output logic       word_valid,
    output code_t      word_code,
    output logic       last_word
)
;

    // digits padded so every group has hundreds, tens and units
    localparam int GRP_BITS = 12 * NUM_GROUPS;

    logic [POS_N-1:0] mask_reg, mask_next;
    logic [POS_N-1:0] mask_load;
    logic [POS_N-1:0] sel;
    logic [POS_N-1:0] mask_rest;
    code_t            pos_code [POS_N];
    code_t            code_sel;
    bcd_t             digits_reg;
    logic             word_valid_reg;
    code_t            word_code_reg;
    logic             last_word_reg;

    // token mask of the value at the queue head
    always_comb
    begin
        digit_t              h, t, u;
        int                  p;
        logic [GRP_BITS-1:0] grp_bits;
        grp_bits     = GRP_BITS'(head.bcd);
        mask_load    = '0;
        mask_load[0] = (head.bcd == '0);
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            p = 1 + (NUM_GROUPS - 1 - g) * GROUP_POS;
            h = grp_bits[12*g + 8 +: 4];
            t = grp_bits[12*g + 4 +: 4];
            u = grp_bits[12*g +: 4];
            mask_load[p]     = (h != '0);
            mask_load[p + 1] = (h != '0);
            mask_load[p + 2] = (t != '0) || (u != '0);
            mask_load[p + 3] = (t >= 4'd2) && (u != '0);
            mask_load[p + 4] = (g != 0) && ((h != '0) || (t != '0) || (u != '0));
        end
    end

    // word code at every token position of the current value
    always_comb
    begin
        digit_t              h, t, u;
        int                  p;
        logic [GRP_BITS-1:0] grp_bits;
        grp_bits = GRP_BITS'(digits_reg);
        for (int i = 0; i < POS_N; i++)
        begin
            pos_code[i] = CODE_ZERO;
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            p = 1 + (NUM_GROUPS - 1 - g) * GROUP_POS;
            h = grp_bits[12*g + 8 +: 4];
            t = grp_bits[12*g + 4 +: 4];
            u = grp_bits[12*g +: 4];
            pos_code[p]     = {1'b0, h};
            pos_code[p + 1] = CODE_HUNDRED;
            if (t >= 4'd2)
            begin
                pos_code[p + 2] = {1'b0, t} + CODE_TWENTY - 5'd2;
            end
            else if (t == 4'd1)
            begin
                pos_code[p + 2] = CODE_TEN + {1'b0, u};
            end
            else
            begin
                pos_code[p + 2] = {1'b0, u};
            end
            pos_code[p + 3] = {1'b0, u};
            if (g == 3)
            begin
                pos_code[p + 4] = CODE_BILLION;
            end
            else if (g == 2)
            begin
                pos_code[p + 4] = CODE_MILLION;
            end
            else
            begin
                pos_code[p + 4] = CODE_THOUSAND;
            end
        end
    end

    // pick the earliest pending token
    assign sel       = mask_reg & (~mask_reg + POS_N'(1));
    assign mask_rest = mask_reg & ~sel;
    assign pop       = (mask_rest == '0) && head.not_empty;
    assign mask_next = pop ? mask_load : mask_rest;

    always_comb
    begin
        code_sel = CODE_ZERO;
        for (int i = 0; i < POS_N; i++)
        begin
            code_sel = code_sel | (sel[i] ? pos_code[i] : CODE_ZERO);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg       <= mask_next;
            word_valid_reg <= (mask_reg != '0);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            digits_reg <= head.bcd;
        end
        word_code_reg <= code_sel;
        last_word_reg <= (mask_rest == '0);
    end

    assign word_valid = word_valid_reg;
    assign word_code  = word_code_reg;
    assign last_word  = last_word_reg;

    `NTEW_ASSERT(a_back_zero_alone, word_valid && (word_code == CODE_ZERO) |-> last_word,
        "zero token not last")
    `NTEW_NEVER(a_back_units_scale, mask_reg[POS_N-1], "scale word on units group")

endmodule
